// ----- rtl/core/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sle_pkg.sv -----
`timescale 1ns / 1ps

package sle_pkg;

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_FIND    = 3'd1,
        OP_READ    = 3'd2,
        OP_REM_AT  = 3'd3,
        OP_REM_VAL = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_BAD      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_CMP   = 2'd1,
        S_APPLY = 2'd2
    } state_t;

    localparam int DATA_W  = 32;
    localparam int POS_W   = 7;
    localparam int OUT_W   = 7;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              cmp;
        logic              ins;
        logic              del;
        logic              by_pos;
        logic [DATA_W-1:0] value;
    } cell_ctl_t;

    // per-cell compare results, held from the compare cycle to the apply cycle
    typedef struct packed {
        logic gt;
        logic le;
        logic eq;
        logic sel;
    } cell_flag_t;

endpackage

// ----- rtl/core/sle_cell.sv -----
`timescale 1ns / 1ps

module sle_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sle_pkg::cell_ctl_t        ctl,
    input  logic [CW-1:0]             count,
    input  logic [CW-1:0]             pidx,
    input  logic                      left_gt,
    input  logic [sle_pkg::DATA_W-1:0] left_val,
    input  logic [sle_pkg::DATA_W-1:0] right_val,
    output sle_pkg::cell_flag_t       flag,
    output logic [sle_pkg::DATA_W-1:0] val
);
    import sle_pkg::*;

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [DATA_W-1:0] val_reg;
    logic              gt_reg, le_reg, eq_reg, sel_reg, sh_reg;
    logic              occ, gt_c, eq_c;

    assign occ  = IDX_C < count;
    assign gt_c = occ && ($signed(val_reg) > $signed(ctl.value));
    assign eq_c = occ && (val_reg == ctl.value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gt_reg  <= 1'b0;
            le_reg  <= 1'b0;
            eq_reg  <= 1'b0;
            sel_reg <= 1'b0;
            sh_reg  <= 1'b0;
        end
        else if (ctl.cmp)
        begin
            gt_reg  <= gt_c;
            le_reg  <= occ && !gt_c;
            eq_reg  <= eq_c;
            sel_reg <= IDX_C == pidx;
            sh_reg  <= ctl.by_pos ? (IDX_C >= pidx) : (gt_c || eq_c);
        end
    end

    // insert: take from the left, or the new value at the boundary; delete: take from the right
    always_ff @(posedge clk)
    begin
        if (ctl.ins && (IDX_C <= count))
        begin
            if (left_gt)
            begin
                val_reg <= left_val;
            end
            else if (gt_reg || (IDX_C == count))
            begin
                val_reg <= ctl.value;
            end
        end
        else if (ctl.del && sh_reg)
        begin
            val_reg <= right_val;
        end
    end

    assign flag.gt  = gt_reg;
    assign flag.le  = le_reg;
    assign flag.eq  = eq_reg;
    assign flag.sel = sel_reg;
    assign val      = val_reg;

endmodule

// ----- rtl/core/sle_ctrl.sv -----
`timescale 1ns / 1ps

module sle_ctrl #(
    parameter int CAPACITY = 64,
    parameter int CW       = 7
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sle_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [2:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sle_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]                      m_axis_tuser,
    input  sle_pkg::cell_flag_t             flags [CAPACITY],
    input  logic [sle_pkg::DATA_W-1:0]      vals  [CAPACITY],
    output sle_pkg::cell_ctl_t              ctl,
    output logic [CW-1:0]                   count,
    output logic [CW-1:0]                   pidx
);
    import sle_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int MW = (CW > POS_W) ? CW : POS_W;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [1:0]             out_user_reg;
    logic [2:0]             op_reg;
    logic [DATA_W-1:0]      val_reg;
    logic [POS_W-1:0]       pos_reg;
    logic                   pos_ok_reg;

    logic                   out_free, accept, cmp, finish, full;
    logic                   pos_ok_c;
    logic                   any_eq, do_ins, do_del;
    logic [IW-1:0]          enc;
    logic [DATA_W-1:0]      rd_val, rv;
    logic [OUT_W-1:0]       ri;
    status_t                st;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign full     = count_reg >= CW'(CAPACITY);

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        cmp           = 1'b0;
        finish        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmp        = 1'b1;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    finish        = 1'b1;
                    s_axis_tready = 1'b1;
                    state_next    = s_axis_tvalid ? S_CMP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // position: all ones means last element
    always_comb
    begin
        pos_ok_c = 1'b0;
        pidx     = CW'(pos_reg);
        if (count_reg != '0)
        begin
            if (pos_reg == {POS_W{1'b1}})
            begin
                pos_ok_c = 1'b1;
                pidx     = count_reg - 1'b1;
            end
            else if (!pos_reg[POS_W-1] && (MW'(pos_reg) < MW'(count_reg)))
            begin
                pos_ok_c = 1'b1;
            end
        end
    end

    // reductions over the cell flags
    always_comb
    begin
        any_eq = 1'b0;
        enc    = '0;
        rd_val = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            any_eq = any_eq | flags[i].eq;
            if (flags[i].sel)
            begin
                rd_val = rd_val | vals[i];
            end
            if (i == CAPACITY - 1)
            begin
                if (flags[i].le)
                begin
                    enc = enc | IW'(i);
                end
            end
            else if (flags[i].le && !flags[i+1].le)
            begin
                enc = enc | IW'(i);
            end
        end
    end

    always_comb
    begin
        rv         = '0;
        ri         = '0;
        st         = ST_OK;
        count_next = count_reg;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        case (op_reg)
            OP_INSERT:
            begin
                if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    do_ins     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_FIND:
            begin
                if (count_reg == '0)
                begin
                    st = ST_BAD;
                end
                else if (flags[0].eq)
                begin
                    ri = '0;
                end
                else if (flags[0].le)
                begin
                    ri = OUT_W'(enc);
                end
                else
                begin
                    ri = {OUT_W{1'b1}};
                end
            end
            OP_READ:
            begin
                if (pos_ok_reg)
                begin
                    rv = rd_val;
                end
                else
                begin
                    st = ST_BAD;
                end
            end
            OP_REM_AT:
            begin
                if (pos_ok_reg)
                begin
                    rv         = rd_val;
                    do_del     = 1'b1;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    st = ST_BAD;
                end
            end
            OP_REM_VAL:
            begin
                if (count_reg == '0)
                begin
                    st = ST_BAD;
                end
                else if (any_eq)
                begin
                    rv         = val_reg;
                    do_del     = 1'b1;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    st = ST_NOTFOUND;
                end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            pos_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmp)
            begin
                pos_ok_reg <= pos_ok_c;
            end
            if (finish)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= s_axis_tuser;
            val_reg <= s_axis_tdata[DATA_W-1:0];
            pos_reg <= s_axis_tdata[DATA_W+POS_W-1:DATA_W];
        end
        if (finish)
        begin
            out_data_reg <= {2'b00, OUT_W'(count_next), ri, rv};
            out_user_reg <= st;
        end
    end

    assign ctl.cmp    = cmp;
    assign ctl.ins    = finish && do_ins;
    assign ctl.del    = finish && do_del;
    assign ctl.by_pos = (op_reg == OP_READ) || (op_reg == OP_REM_AT);
    assign ctl.value  = val_reg;
    assign count      = count_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// ----- rtl/core/sorted_list_engine_top.sv -----
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                                    tuser
// s_axis    in   value[31:0], position[38:32], zero pad [39]            opcode
// m_axis    out  result_value[31:0], result_index[38:32],               status
//                element_count[45:39], zero pad [47:46]
//
// Each item takes a compare step across all cells, then an apply step that
// shifts the cell row and loads the output register; tready is high again in
// the apply step once the output is free. A stalled output holds the apply step.
// Reset clears the count, the controller and the output valid; cell contents
// are not reset.

module sorted_list_engine_top #(
    parameter int CAPACITY = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sle_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // value, position
    input  logic [2:0]                      s_axis_tuser,  // opcode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sle_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // result_value, result_index, element_count
    output logic [1:0]                      m_axis_tuser   // status
);
    import sle_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    cell_ctl_t         ctl;
    cell_flag_t        flags [CAPACITY];
    logic [DATA_W-1:0] vals  [CAPACITY];
    logic [CW-1:0]     count;
    logic [CW-1:0]     pidx;

    sle_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .flags         (flags),
        .vals          (vals),
        .ctl           (ctl),
        .count         (count),
        .pidx          (pidx)
    );

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic              left_gt;
        logic [DATA_W-1:0] left_val;
        logic [DATA_W-1:0] right_val;

        if (g == 0)
        begin : g_first
            assign left_gt  = 1'b0;
            assign left_val = vals[g];
        end
        else
        begin : g_inner_l
            assign left_gt  = flags[g-1].gt;
            assign left_val = vals[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_val = vals[g];
        end
        else
        begin : g_inner_r
            assign right_val = vals[g+1];
        end

        sle_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .count     (count),
            .pidx      (pidx),
            .left_gt   (left_gt),
            .left_val  (left_val),
            .right_val (right_val),
            .flag      (flags[g]),
            .val       (vals[g])
        );
    end

endmodule

// ----- rtl/core/sle_checker.sv -----
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sle_checker #(
    parameter int CAPACITY = 64
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [sle_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]                      m_axis_tuser
);
    import sle_pkg::*;

    logic [DATA_W-1:0] res_val;
    logic [OUT_W-1:0]  res_idx;
    logic [OUT_W-1:0]  res_cnt;

    assign res_val = m_axis_tdata[DATA_W-1:0];
    assign res_idx = m_axis_tdata[DATA_W+OUT_W-1:DATA_W];
    assign res_cnt = m_axis_tdata[DATA_W+2*OUT_W-1:DATA_W+OUT_W];

    `SLE_ASSERT_NOW(a_fail_zero, m_axis_tvalid && (m_axis_tuser != ST_OK),
        (res_val == '0) && (res_idx == '0), "failed item carries nonzero payload")

    `SLE_ASSERT_NOW(a_full_count, m_axis_tvalid && (m_axis_tuser == ST_FULL),
        res_cnt == OUT_W'(CAPACITY), "store full reported below capacity")

    `SLE_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "item accepted while previous one still comparing")

    `SLE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "stalled result changed")

endmodule

bind sorted_list_engine_top sle_checker #(
    .CAPACITY (CAPACITY)
) u_sle_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
